// ----- rtl/core/iwc_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwc_pkg
// Shared types, codes and field constants for the instruction word codec.
// ----------------------------------------------------------------------------
package iwc_pkg;

    // Widths of the packed stream beats.
    localparam int unsigned InDataW  = 72;
    localparam int unsigned OutDataW = 64;

    // Field masks of the instruction word.
    localparam logic [15:0] MaskClass   = 16'hF000;
    localparam logic [15:0] ClassAWord  = 16'hA000;
    localparam logic [15:0] ClassFWord  = 16'hF000;
    localparam logic [15:0] MaskClassA  = 16'hFF80;
    localparam logic [15:0] MnemClassA  = 16'hF380;
    localparam logic [15:0] BitsImm8Cls = 16'h0C00;
    localparam logic [15:0] BitImm8     = 16'h0800;
    localparam logic [15:0] BitImm4     = 16'h0400;
    localparam logic [15:0] MaskCond3   = 16'h0380;
    localparam logic [15:0] MaskCond4   = 16'h03C0;

    // Class nibbles (word bits 15..12).
    localparam logic [3:0] NibA = 4'hA;
    localparam logic [3:0] NibB = 4'hB;
    localparam logic [3:0] NibC = 4'hC;
    localparam logic [3:0] NibD = 4'hD;
    localparam logic [3:0] NibE = 4'hE;

    // Immediate and condition sizes.
    localparam logic [3:0] ImmSize4  = 4'd4;
    localparam logic [3:0] ImmSize8  = 4'd8;
    localparam logic [3:0] ImmSize9  = 4'd9;
    localparam logic [3:0] ImmSizeNo = 4'd0;
    localparam logic [2:0] CondSize3 = 3'd3;
    localparam logic [2:0] CondSize4 = 3'd4;

    // Immediate field masks.
    localparam logic [15:0] ImmMask4 = 16'h000F;
    localparam logic [15:0] ImmMask8 = 16'h00FF;
    localparam logic [15:0] ImmMask9 = 16'h01FF;

    typedef enum logic [1:0] {
        ACT_IMM_ENC = 2'd0,
        ACT_REG_ENC = 2'd1,
        ACT_DECODE  = 2'd2
    } t_action;

    typedef enum logic [2:0] {
        CL_IMM8 = 3'd0,
        CL_IMM4 = 3'd1,
        CL_RES  = 3'd2,
        CL_IMM9 = 3'd3,
        CL_PF   = 3'd4,
        CL_INV  = 3'd5
    } t_class;

    typedef enum logic [2:0] {
        FM_NONE        = 3'd0,
        FM_REG_CND     = 3'd1,
        FM_IMM_REG     = 3'd2,
        FM_IMM_REG_CND = 3'd3,
        FM_REG_REG_CND = 3'd4,
        FM_REG_REG     = 3'd5
    } t_form;

    // One input item.
    typedef struct packed {
        t_action     action;
        logic [15:0] class_template;
        logic [15:0] imm_value;
        logic [3:0]  imm_width;
        logic [2:0]  src_reg;
        logic [2:0]  dst_reg;
        logic [3:0]  cond_code;
        logic [2:0]  cond_width;
        logic [15:0] word_in;
    } t_item;

    // Word built by the encoder, before any immediate is added.
    typedef struct packed {
        logic [15:0] word;
        logic        invalid;
    } t_build;

    // Fields of a split word.
    typedef struct packed {
        t_class      cls;
        t_form       form;
        logic [15:0] mnem;
        logic [2:0]  src;
        logic [2:0]  dst;
        logic [3:0]  cond;
        logic [8:0]  imm;
        logic [3:0]  isize;
    } t_fields;

    // One result item.
    typedef struct packed {
        logic [15:0] word_out;
        logic        invalid;
        logic        imm_overflow;
        t_fields     flds;
    } t_result;

endpackage

// ----- rtl/core/instruction_word_codec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// instruction_word_codec
// Encodes and decodes 16-bit instruction words, one item per beat.
// ----------------------------------------------------------------------------
//  Channel   Direction  Ports                              Payload
//  s         in         i_s_tvalid/o_s_tready/i_s_tdata    one action (72 bits)
//  m         out        o_m_tvalid/i_m_tready/o_m_tdata    one result (64 bits)
//
//  An input beat is registered, worked on by the build, split and immediate
//  merge logic, and the result is registered; one beat is accepted every
//  cycle while the output is not stalled.
//  A result held by a stalled output still lets one more beat into the input
//  register. Reset (i_rst_n low, synchronous) empties both stages.
// ----------------------------------------------------------------------------
module instruction_word_codec (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // action[1:0], class_template[17:2], imm_value[33:18], imm_width[37:34],
    // src_reg[40:38], dst_reg[43:41], cond_code[47:44], cond_width[50:48],
    // word_in[66:51], zero fill[71:67]
    input  logic [71:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // word_out[15:0], invalid[16], imm_overflow[17], class_code[20:18],
    // form_code[23:21], mnemonic_bits[39:24], src_field[42:40],
    // dst_field[45:43], cond_field[49:46], imm_field[58:50],
    // imm_size_field[62:59], zero fill[63]
    output logic [63:0] o_m_tdata
);

    iwc_pkg::t_item   n_in;
    iwc_pkg::t_item   r_in;
    logic             r_in_valid;
    iwc_pkg::t_result n_out;
    iwc_pkg::t_result r_out;
    logic             r_out_valid;
    logic             w_adv;
    iwc_pkg::t_build  w_build;
    iwc_pkg::t_fields w_flds;
    logic [15:0]      w_mask;
    logic [8:0]       w_imm;
    logic             w_has_imm;

    // Unpack the input beat.
    assign n_in.action         = iwc_pkg::t_action'(i_s_tdata[1:0]);
    assign n_in.class_template = i_s_tdata[17:2];
    assign n_in.imm_value      = i_s_tdata[33:18];
    assign n_in.imm_width      = i_s_tdata[37:34];
    assign n_in.src_reg        = i_s_tdata[40:38];
    assign n_in.dst_reg        = i_s_tdata[43:41];
    assign n_in.cond_code      = i_s_tdata[47:44];
    assign n_in.cond_width     = i_s_tdata[50:48];
    assign n_in.word_in        = i_s_tdata[66:51];

    // Pipeline flow: the result stage moves when empty or taken.
    assign w_adv      = !r_out_valid || i_m_tready;
    assign o_s_tready = !r_in_valid || w_adv;

    iwc_build u_build (
        .i_item  (r_in),
        .o_build (w_build)
    );

    iwc_split u_split (
        .i_word (w_build.word),
        .o_flds (w_flds)
    );

    // Immediate mask follows the decoded size.
    always_comb begin
        case (w_flds.isize)
            iwc_pkg::ImmSize4: w_mask = iwc_pkg::ImmMask4;
            iwc_pkg::ImmSize8: w_mask = iwc_pkg::ImmMask8;
            default:           w_mask = iwc_pkg::ImmMask9;
        endcase
    end

    assign w_has_imm = (r_in.action == iwc_pkg::ACT_IMM_ENC)
                    && (w_flds.form == iwc_pkg::FM_IMM_REG
                        || w_flds.form == iwc_pkg::FM_IMM_REG_CND);
    assign w_imm     = r_in.imm_value[8:0] & w_mask[8:0];

    // Merge the immediate into the built word and form the result.
    always_comb begin
        n_out              = '0;
        n_out.word_out     = w_build.word;
        n_out.flds         = w_flds;
        if (w_build.invalid) begin
            n_out         = '0;
            n_out.invalid = 1'b1;
        end else if (w_has_imm) begin
            n_out.imm_overflow = |(r_in.imm_value & ~w_mask);
            n_out.flds.imm     = w_imm;
            n_out.word_out     = w_build.word + {4'd0, w_imm, 3'd0};
        end
    end

    // Stage valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    // Stage payloads.
    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in <= n_in;
        end
        if (w_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    // Pack the output beat.
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {1'b0,
                         r_out.flds.isize,
                         r_out.flds.imm,
                         r_out.flds.cond,
                         r_out.flds.dst,
                         r_out.flds.src,
                         r_out.flds.mnem,
                         r_out.flds.form,
                         r_out.flds.cls,
                         r_out.imm_overflow,
                         r_out.invalid,
                         r_out.word_out};

endmodule

// ----- rtl/core/iwc_build.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwc_build
// Builds the instruction word for an encode action, or passes the word to be
// decoded straight through.
// ----------------------------------------------------------------------------
module iwc_build (
    input  iwc_pkg::t_item  i_item,
    output iwc_pkg::t_build o_build
);

    logic        w_class_a;
    logic        w_class_f;
    logic [15:0] w_base;

    assign w_class_a = (i_item.class_template & iwc_pkg::MaskClass) == iwc_pkg::ClassAWord;
    assign w_class_f = (i_item.class_template & iwc_pkg::MaskClass) == iwc_pkg::ClassFWord;

    // Class nibble and destination register, common to both encode actions.
    assign w_base = (i_item.class_template & iwc_pkg::MaskClass) | {13'd0, i_item.dst_reg};

    // Word assembly per action; an unused action code decodes.
    always_comb begin
        o_build.word    = i_item.word_in;
        o_build.invalid = 1'b0;
        case (i_item.action)
            iwc_pkg::ACT_IMM_ENC: begin
                if (w_class_a) begin
                    o_build.word = (i_item.class_template & iwc_pkg::MaskClassA)
                                 | iwc_pkg::BitsImm8Cls | {13'd0, i_item.dst_reg};
                end else if (i_item.imm_width == iwc_pkg::ImmSize8) begin
                    o_build.word = w_base | iwc_pkg::BitImm8;
                end else if (i_item.imm_width == iwc_pkg::ImmSize4) begin
                    o_build.word = w_base | iwc_pkg::BitImm4
                                 | ({6'd0, i_item.cond_code, 6'd0} & iwc_pkg::MaskCond3);
                end else if (i_item.imm_width == iwc_pkg::ImmSize9) begin
                    o_build.word = w_base;
                end else begin
                    o_build.word    = w_base;
                    o_build.invalid = 1'b1;
                end
            end
            iwc_pkg::ACT_REG_ENC: begin
                if (w_class_a) begin
                    o_build.word = (i_item.class_template & iwc_pkg::MaskClassA)
                                 | {13'd0, i_item.dst_reg};
                end else if (i_item.cond_width == iwc_pkg::CondSize3) begin
                    o_build.word = w_base
                                 | ({6'd0, i_item.cond_code, 6'd0} & iwc_pkg::MaskCond3);
                end else if (i_item.cond_width == iwc_pkg::CondSize4) begin
                    o_build.word = w_base
                                 | ({6'd0, i_item.cond_code, 6'd0} & iwc_pkg::MaskCond4);
                end else begin
                    o_build.word = w_base;
                end
                // Class F words carry no source register.
                if (!w_class_f) begin
                    o_build.word = o_build.word | {10'd0, i_item.src_reg, 3'd0};
                end
            end
            default: begin
                o_build.word    = i_item.word_in;
                o_build.invalid = 1'b0;
            end
        endcase
    end

endmodule

// ----- rtl/core/iwc_split.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iwc_split
// Splits an instruction word into class, form, mnemonic, register,
// condition and immediate fields.
// ----------------------------------------------------------------------------
module iwc_split (
    input  logic [15:0]      i_word,
    output iwc_pkg::t_fields o_flds
);

    logic [3:0] w_nib;

    assign w_nib = i_word[15:12];

    always_comb begin
        o_flds       = '0;
        o_flds.mnem  = {w_nib, 12'd0};
        o_flds.dst   = i_word[2:0];

        // Class from the top nibble.
        case (w_nib) inside
            iwc_pkg::NibA: begin
                o_flds.cls  = iwc_pkg::CL_IMM4;
                o_flds.mnem = i_word & iwc_pkg::MnemClassA;
            end
            iwc_pkg::NibB:                 o_flds.cls = iwc_pkg::CL_RES;
            iwc_pkg::NibC, iwc_pkg::NibD:  o_flds.cls = iwc_pkg::CL_IMM9;
            iwc_pkg::NibE:                 o_flds.cls = iwc_pkg::CL_PF;
            [4'h0 : 4'h9]:                 o_flds.cls = iwc_pkg::CL_IMM8;
            default:                       o_flds.cls = iwc_pkg::CL_INV;
        endcase

        // Form, immediate and source register.
        if (o_flds.cls == iwc_pkg::CL_INV) begin
            o_flds.form = iwc_pkg::FM_NONE;
        end else if (o_flds.cls == iwc_pkg::CL_PF) begin
            o_flds.form = iwc_pkg::FM_REG_CND;
        end else if (o_flds.cls == iwc_pkg::CL_IMM9) begin
            o_flds.isize = iwc_pkg::ImmSize9;
            o_flds.imm   = i_word[11:3];
            o_flds.form  = iwc_pkg::FM_IMM_REG;
        end else if (i_word[11]) begin
            o_flds.isize = iwc_pkg::ImmSize8;
            o_flds.imm   = {1'b0, i_word[10:3]};
            o_flds.form  = iwc_pkg::FM_IMM_REG;
        end else if (i_word[10]) begin
            o_flds.isize = iwc_pkg::ImmSize4;
            o_flds.imm   = {5'd0, i_word[6:3]};
            o_flds.form  = (o_flds.cls == iwc_pkg::CL_IMM4) ? iwc_pkg::FM_IMM_REG
                                                            : iwc_pkg::FM_IMM_REG_CND;
        end else begin
            o_flds.src  = i_word[5:3];
            o_flds.form = (o_flds.cls == iwc_pkg::CL_IMM4) ? iwc_pkg::FM_REG_REG
                                                           : iwc_pkg::FM_REG_REG_CND;
        end

        // Condition field, three or four bits depending on the form.
        if (o_flds.form == iwc_pkg::FM_IMM_REG_CND) begin
            o_flds.cond = {i_word[9:7], 1'b0};
        end else if (o_flds.form == iwc_pkg::FM_REG_REG_CND
                     || o_flds.form == iwc_pkg::FM_REG_CND) begin
            o_flds.cond = i_word[9:6];
        end
    end

endmodule

// ----- sim/tb_instruction_word_codec.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_instruction_word_codec
// Self-checking bench for the instruction word codec. Directed beats cover the
// immediate sizes, the register forms, every class and the decode edge
// cases; random beats then run with bursts of idling on both sides, a long
// output hold-off and a full-rate tail. Every accepted input beat is predicted
// in the bench and each output beat is checked field by field.
// ----------------------------------------------------------------------------
module tb_instruction_word_codec;

    localparam int unsigned WatchdogLimit = 2000;
    localparam int unsigned HoldCycles    = 64;
    localparam int unsigned TailCycles    = 10;
    localparam int unsigned MaxReports    = 10;
    // The spare action code, which the block treats as a decode.
    localparam logic [1:0]  ActSpare      = 2'd3;

    // One instruction request as it travels on the input stream.
    typedef struct {
        logic [1:0]  action;
        logic [15:0] templ;
        logic [15:0] imm_val;
        logic [3:0]  imm_w;
        logic [2:0]  src;
        logic [2:0]  dst;
        logic [3:0]  cond;
        logic [2:0]  cond_w;
        logic [15:0] word;
    } t_codec_item;

    // One codec answer, field by field.
    typedef struct {
        logic [15:0] word;
        logic        inv;
        logic        ovf;
        logic [2:0]  cls;
        logic [2:0]  form;
        logic [15:0] mnem;
        logic [2:0]  src;
        logic [2:0]  dst;
        logic [3:0]  cond;
        logic [8:0]  imm;
        logic [3:0]  isize;
    } t_codec_res;

    logic        clk     = 1'b0;
    logic        rst_n   = 1'b0;
    logic        s_valid = 1'b0;
    logic [71:0] s_data  = '0;
    logic        m_ready = 1'b1;
    logic        s_ready;
    logic        m_valid;
    logic [63:0] m_data;

    t_codec_res  expected_results[$];
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned mismatch_cnt  = 0;
    int unsigned idle_cycles   = 0;
    bit          tx_gap_en     = 1'b1;
    bit          rx_stall_en   = 1'b1;
    bit          rx_hold_req   = 1'b0;
    bit          rx_hold_active = 1'b0;

    instruction_word_codec u_top (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_valid),
        .o_s_tready (s_ready),
        .i_s_tdata  (s_data),
        .o_m_tvalid (m_valid),
        .i_m_tready (m_ready),
        .o_m_tdata  (m_data)
    );

    // Free-running clock, 8 ns period.
    always begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Splits a word into its class, form and operand fields.
    function automatic t_codec_res word_fields(input logic [15:0] w);
        t_codec_res f;
        logic [3:0] nib;
        f     = '{default: '0};
        nib   = w[15:12];
        f.word = w;
        f.mnem = w & iwc_pkg::MaskClass;
        if (nib < iwc_pkg::NibA) begin
            f.cls = iwc_pkg::CL_IMM8;
        end else if (nib == iwc_pkg::NibA) begin
            f.cls  = iwc_pkg::CL_IMM4;
            f.mnem = w & iwc_pkg::MnemClassA;
        end else if (nib == iwc_pkg::NibB) begin
            f.cls = iwc_pkg::CL_RES;
        end else if (nib == iwc_pkg::NibC || nib == iwc_pkg::NibD) begin
            f.cls = iwc_pkg::CL_IMM9;
        end else if (nib == iwc_pkg::NibE) begin
            f.cls = iwc_pkg::CL_PF;
        end else begin
            f.cls = iwc_pkg::CL_INV;
        end

        // The form follows from the class and the two size bits.
        if (f.cls == iwc_pkg::CL_INV) begin
            f.form = iwc_pkg::FM_NONE;
        end else if (f.cls == iwc_pkg::CL_PF) begin
            f.form = iwc_pkg::FM_REG_CND;
        end else if (f.cls == iwc_pkg::CL_IMM9) begin
            f.isize = iwc_pkg::ImmSize9;
            f.imm   = w[11:3];
            f.form  = iwc_pkg::FM_IMM_REG;
        end else if (w[11]) begin
            f.isize = iwc_pkg::ImmSize8;
            f.imm   = {1'b0, w[10:3]};
            f.form  = iwc_pkg::FM_IMM_REG;
        end else if (w[10]) begin
            f.isize = iwc_pkg::ImmSize4;
            f.imm   = {5'b0, w[6:3]};
            f.form  = (f.cls == iwc_pkg::CL_IMM4) ? iwc_pkg::FM_IMM_REG
                                                  : iwc_pkg::FM_IMM_REG_CND;
        end else begin
            f.src  = w[5:3];
            f.form = (f.cls == iwc_pkg::CL_IMM4) ? iwc_pkg::FM_REG_REG
                                                 : iwc_pkg::FM_REG_REG_CND;
        end

        // A 3-bit condition lands one place up, so its low bit reads as zero.
        if (f.form == iwc_pkg::FM_IMM_REG_CND) begin
            f.cond = {w[9:7], 1'b0};
        end else if (f.form == iwc_pkg::FM_REG_REG_CND || f.form == iwc_pkg::FM_REG_CND) begin
            f.cond = w[9:6];
        end
        f.dst = w[2:0];
        return f;
    endfunction

    // Works out the codec answer for one accepted request.
    function automatic t_codec_res codec_predict(input t_codec_item it);
        t_codec_res  r;
        logic [15:0] w;
        logic [15:0] mask;
        logic        class_a;
        class_a = (it.templ & iwc_pkg::MaskClass) == iwc_pkg::ClassAWord;
        if (it.action == iwc_pkg::ACT_IMM_ENC) begin
            if (class_a) begin
                // Class A always takes the 8-bit immediate form.
                w = (it.templ & iwc_pkg::MaskClassA) | iwc_pkg::BitsImm8Cls
                  | {13'b0, it.dst};
            end else begin
                w = (it.templ & iwc_pkg::MaskClass) | {13'b0, it.dst};
                if (it.imm_w == iwc_pkg::ImmSize8) begin
                    w = w | iwc_pkg::BitImm8;
                end else if (it.imm_w == iwc_pkg::ImmSize4) begin
                    w = w | iwc_pkg::BitImm4 | ({6'b0, it.cond, 6'b0} & iwc_pkg::MaskCond3);
                end else if (it.imm_w != iwc_pkg::ImmSize9) begin
                    r     = '{default: '0};
                    r.inv = 1'b1;
                    return r;
                end
            end
            r = word_fields(w);
            // Only a word with an immediate form takes the operand.
            if (r.form == iwc_pkg::FM_IMM_REG || r.form == iwc_pkg::FM_IMM_REG_CND) begin
                mask   = (r.isize == iwc_pkg::ImmSize4) ? iwc_pkg::ImmMask4 :
                         (r.isize == iwc_pkg::ImmSize8) ? iwc_pkg::ImmMask8 :
                                                          iwc_pkg::ImmMask9;
                r.ovf  = it.imm_val > mask;
                r.imm  = it.imm_val[8:0] & mask[8:0];
                r.word = w + {4'b0, r.imm, 3'b0};
            end
        end else if (it.action == iwc_pkg::ACT_REG_ENC) begin
            if (class_a) begin
                w = (it.templ & iwc_pkg::MaskClassA) | {13'b0, it.dst};
            end else begin
                w = (it.templ & iwc_pkg::MaskClass) | {13'b0, it.dst};
                if (it.cond_w == iwc_pkg::CondSize3) begin
                    w = w | ({6'b0, it.cond, 6'b0} & iwc_pkg::MaskCond3);
                end else if (it.cond_w == iwc_pkg::CondSize4) begin
                    w = w | ({6'b0, it.cond, 6'b0} & iwc_pkg::MaskCond4);
                end
            end
            if ((it.templ & iwc_pkg::MaskClass) != iwc_pkg::ClassFWord) begin
                w = w | {10'b0, it.src, 3'b0};
            end
            r = word_fields(w);
        end else begin
            r = word_fields(it.word);
        end
        return r;
    endfunction

    function automatic t_codec_item mk_item(
        input logic [1:0]  action,
        input logic [15:0] templ,
        input logic [15:0] imm_val,
        input logic [3:0]  imm_w,
        input logic [2:0]  src,
        input logic [2:0]  dst,
        input logic [3:0]  cond,
        input logic [2:0]  cond_w,
        input logic [15:0] word
    );
        t_codec_item it;
        it.action  = action;
        it.templ   = templ;
        it.imm_val = imm_val;
        it.imm_w   = imm_w;
        it.src     = src;
        it.dst     = dst;
        it.cond    = cond;
        it.cond_w  = cond_w;
        it.word    = word;
        return it;
    endfunction

    // Random request, weighted towards the valid immediate and condition sizes.
    function automatic t_codec_item rand_item();
        t_codec_item it;
        int unsigned pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            it.action = iwc_pkg::ACT_IMM_ENC;
        end else if (pick < 7) begin
            it.action = iwc_pkg::ACT_REG_ENC;
        end else if (pick < 9) begin
            it.action = iwc_pkg::ACT_DECODE;
        end else begin
            it.action = ActSpare;
        end
        it.templ   = 16'($urandom);
        it.imm_val = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 16'h01FF))
                                                 : 16'($urandom);
        case ($urandom_range(0, 7))
            0, 1:    it.imm_w = iwc_pkg::ImmSize4;
            2, 3:    it.imm_w = iwc_pkg::ImmSize8;
            4, 5:    it.imm_w = iwc_pkg::ImmSize9;
            default: it.imm_w = 4'($urandom);
        endcase
        case ($urandom_range(0, 5))
            0, 1:    it.cond_w = iwc_pkg::CondSize3;
            2, 3:    it.cond_w = iwc_pkg::CondSize4;
            default: it.cond_w = 3'($urandom);
        endcase
        it.src  = 3'($urandom);
        it.dst  = 3'($urandom);
        it.cond = 4'($urandom);
        it.word = 16'($urandom);
        return it;
    endfunction

    // Offers one beat and waits for it to be taken, then maybe idles a little.
    task automatic send_item(input t_codec_item it);
        s_valid <= 1'b1;
        s_data  <= {5'b0, it.word, it.cond_w, it.cond, it.dst, it.src, it.imm_w,
                    it.imm_val, it.templ, it.action};
        do @(posedge clk); while (!s_ready);
        items_sent++;
        if (tx_gap_en && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
    endtask

    task automatic wait_results_drained();
        while (results_seen < items_sent) @(posedge clk);
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (got !== want) begin
            mismatch_cnt++;
            if (mismatch_cnt <= MaxReports) begin
                $display("mismatch on %s in result %0d: expected 0x%h, got 0x%h",
                         name, results_seen, want, got);
            end
        end
    endtask

    // Predicts each accepted input beat and checks each accepted output beat.
    always @(posedge clk) begin : scoreboard
        t_codec_item it;
        t_codec_res  got;
        t_codec_res  want;
        if (rst_n) begin
            if (m_valid && m_ready) begin
                got.word  = m_data[15:0];
                got.inv   = m_data[16];
                got.ovf   = m_data[17];
                got.cls   = m_data[20:18];
                got.form  = m_data[23:21];
                got.mnem  = m_data[39:24];
                got.src   = m_data[42:40];
                got.dst   = m_data[45:43];
                got.cond  = m_data[49:46];
                got.imm   = m_data[58:50];
                got.isize = m_data[62:59];
                if (expected_results.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= MaxReports) begin
                        $display("result beat 0x%h arrived with nothing expected", m_data);
                    end
                end else begin
                    want = expected_results.pop_front();
                    check_field("word_out", want.word, got.word);
                    check_field("invalid", 16'(want.inv), 16'(got.inv));
                    check_field("imm_overflow", 16'(want.ovf), 16'(got.ovf));
                    check_field("class_code", 16'(want.cls), 16'(got.cls));
                    check_field("form_code", 16'(want.form), 16'(got.form));
                    check_field("mnemonic_bits", want.mnem, got.mnem);
                    check_field("src_field", 16'(want.src), 16'(got.src));
                    check_field("dst_field", 16'(want.dst), 16'(got.dst));
                    check_field("cond_field", 16'(want.cond), 16'(got.cond));
                    check_field("imm_field", 16'(want.imm), 16'(got.imm));
                    check_field("imm_size_field", 16'(want.isize), 16'(got.isize));
                end
                results_seen++;
            end
            if (s_valid && s_ready) begin
                it.action  = s_data[1:0];
                it.templ   = s_data[17:2];
                it.imm_val = s_data[33:18];
                it.imm_w   = s_data[37:34];
                it.src     = s_data[40:38];
                it.dst     = s_data[43:41];
                it.cond    = s_data[47:44];
                it.cond_w  = s_data[50:48];
                it.word    = s_data[66:51];
                expected_results.push_back(codec_predict(it));
            end
        end
    end

    // Output ready: random short stalls, or a long hold-off on request.
    initial begin : rx_ready_gen
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_active = 1'b1;
                m_ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                m_ready <= 1'b1;
                rx_hold_req    = 1'b0;
                rx_hold_active = 1'b0;
            end else if (rx_stall_en && $urandom_range(0, 4) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // Ends the run when no beat moves on either side for too long.
    always @(posedge clk) begin
        if (!rst_n || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WatchdogLimit) begin
            $display("watchdog: no beat moved for %0d cycles", idle_cycles);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Immediate encode over the sizes, overflow, bad sizes and odd classes.
    task automatic test_imm_encode();
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'h0000, 16'h0000, iwc_pkg::ImmSize4,
                          3'd0, 3'd0, 4'h0, 3'd0, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'h9FFF, 16'hFFFF, iwc_pkg::ImmSize8,
                          3'd7, 3'd7, 4'hF, 3'd7, 16'hFFFF));
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'hD123, 16'h01FF, iwc_pkg::ImmSize9,
                          3'd0, 3'd5, 4'h0, 3'd0, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'hC000, 16'h0200, iwc_pkg::ImmSize8,
                          3'd0, 3'd1, 4'h0, 3'd0, 16'h0000));
        // Class A ignores the size request, even an illegal one.
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'hAF80, 16'hFFFF, 4'd3,
                          3'd0, 3'd7, 4'h0, 3'd0, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'h5000, 16'h0010, iwc_pkg::ImmSize4,
                          3'd0, 3'd2, 4'hF, 3'd0, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'h3000, 16'h0001, iwc_pkg::ImmSizeNo,
                          3'd0, 3'd3, 4'h1, 3'd0, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'hF000, 16'h0001, 4'hF,
                          3'd0, 3'd3, 4'h1, 3'd0, 16'h0000));
        // Sizes that leave the built word without an immediate form, then class B with size 4.
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'hE000, 16'h00FF, iwc_pkg::ImmSize8,
                          3'd0, 3'd4, 4'h0, 3'd0, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'hF000, 16'h01FF, iwc_pkg::ImmSize9,
                          3'd0, 3'd6, 4'h0, 3'd0, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'h1000, 16'hFFFF, iwc_pkg::ImmSize9,
                          3'd0, 3'd1, 4'h0, 3'd0, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_IMM_ENC, 16'hB000, 16'h000F, iwc_pkg::ImmSize4,
                          3'd0, 3'd0, 4'h5, 3'd0, 16'h0000));
    endtask

    // Register encode: both condition sizes, no condition, class F and class A.
    task automatic test_reg_encode();
        send_item(mk_item(iwc_pkg::ACT_REG_ENC, 16'h2000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd7, 3'd3, 4'hF, iwc_pkg::CondSize4, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_REG_ENC, 16'h6000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd1, 3'd0, 4'hF, iwc_pkg::CondSize3, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_REG_ENC, 16'hF000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd7, 3'd7, 4'hF, iwc_pkg::CondSize4, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_REG_ENC, 16'hA380, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd5, 3'd2, 4'hA, iwc_pkg::CondSize4, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_REG_ENC, 16'hE000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd2, 3'd6, 4'hF, 3'd7, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_REG_ENC, 16'hC000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd4, 3'd1, 4'h9, 3'd0, 16'h0000));
    endtask

    // Decode of the extreme words and of every class but CL_IMM9 and every form but FM_REG_REG; action 3 too.
    task automatic test_decode();
        send_item(mk_item(iwc_pkg::ACT_DECODE, 16'h0000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd0, 3'd0, 4'h0, 3'd0, 16'h0000));
        send_item(mk_item(iwc_pkg::ACT_DECODE, 16'h0000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd0, 3'd0, 4'h0, 3'd0, 16'hFFFF));
        send_item(mk_item(ActSpare, 16'h0000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd0, 3'd0, 4'h0, 3'd0, 16'hA400));
        send_item(mk_item(iwc_pkg::ACT_DECODE, 16'h0000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd0, 3'd0, 4'h0, 3'd0, 16'hA800));
        send_item(mk_item(iwc_pkg::ACT_DECODE, 16'h0000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd0, 3'd0, 4'h0, 3'd0, 16'hB7FF));
        send_item(mk_item(ActSpare, 16'h0000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd0, 3'd0, 4'h0, 3'd0, 16'h03C7));
        send_item(mk_item(iwc_pkg::ACT_DECODE, 16'h0000, 16'h0000, iwc_pkg::ImmSizeNo,
                          3'd0, 3'd0, 4'h0, 3'd0, 16'hE3C0));
    endtask

    task automatic test_random_mix(input int unsigned count);
        repeat (count) send_item(rand_item());
    endtask

    // The output holds off for a long stretch while beats keep being offered.
    task automatic test_hold_off(input int unsigned count);
        tx_gap_en   = 1'b0;
        rx_hold_req = 1'b1;
        // Nothing is offered while waiting for the hold-off to begin.
        s_valid <= 1'b0;
        while (!rx_hold_active) @(posedge clk);
        repeat (count) send_item(rand_item());
        tx_gap_en = 1'b1;
    endtask

    // The input pauses until every result of a short burst is back.
    task automatic test_drain_pause(input int unsigned count);
        tx_gap_en = 1'b0;
        repeat (count) send_item(rand_item());
        s_valid <= 1'b0;
        wait_results_drained();
        tx_gap_en = 1'b1;
    endtask

    // Back-to-back beats with no idling on either side.
    task automatic test_full_rate(input int unsigned count);
        tx_gap_en   = 1'b0;
        rx_stall_en = 1'b0;
        repeat (count) send_item(rand_item());
    endtask

    initial begin : stimulus
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_imm_encode();
        test_reg_encode();
        test_decode();
        test_random_mix(300);
        test_hold_off(30);
        test_drain_pause(20);
        test_random_mix(20);
        test_full_rate(150);

        // Let the pipeline empty, then allow a short tail for stray beats.
        s_valid <= 1'b0;
        wait_results_drained();
        repeat (TailCycles) @(posedge clk);
        if (expected_results.size() != 0) begin
            $display("%0d expected results never arrived", expected_results.size());
            mismatch_cnt += expected_results.size();
        end
        if (mismatch_cnt == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
